/* hw/rtl/mlbc_pkg.sv */
package mlbc_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_QUERY = 2'd3
  } act_t;

  // Register numbers; each register sits at byte address 8 * number.
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_COUNT  = 2'd1;
  localparam logic [1:0] REG_MAP    = 2'd2;

  localparam logic [63:0] MAP_RESET = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          PIN_W     = 8;
  localparam int          MAX_CHAN  = 8;

  typedef struct packed {
    act_t        action;
    logic [7:0]  pin;
    logic [31:0] blink_total;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  led_drive;
    logic [7:0]  done_mask;
    logic        pin_found;
    logic [31:0] count_left;
  } out_res_t;

  // Per-channel record held in the channel memory.
  typedef struct packed {
    logic        phase;
    logic        last_phase;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [31:0] remaining;
    logic [31:0] stamp;
  } chan_rec_t;

endpackage

/* hw/rtl/multi_led_blink_controller_core.sv */
// Multi-channel LED blinker. A request is accepted on a clock edge where start is high
// and busy is low, and its single result appears on out_res for exactly one cycle with
// out_valid high, in the first cycle in which busy is low again (for a tick with
// blinking disabled, which never raises busy, the cycle right after the request is
// taken); the receiver cannot stall it, so results must be taken when shown. A tick
// with blinking enabled keeps busy high while the channels in use (led_count, clamped
// to NUM_CHANNELS) are read from the channel memory and written back one channel per
// cycle; start and stop requests are busy for their lookup state, a query also for an
// extra memory read, and a tick with blinking disabled is answered without raising busy.
// The next request may be issued in the cycle in which the previous result is shown.
// The user writes configuration over the APB port only while idle; no check enforces it.
module multi_led_blink_controller_core
  import mlbc_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  // result channel
  output logic        out_valid,
  output out_res_t    out_res,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_QRY  = 4'b0100,
    ST_SCAN = 4'b1000
  } state_t;

  // Control state.
  state_t                  state_r, state_nxt;
  logic [31:0]             time_r, time_nxt;
  logic                    en_r;
  logic [3:0]              cnt_r;
  logic [63:0]             map_r;
  logic [NUM_CHANNELS-1:0] active_r, active_nxt;
  logic [NUM_CHANNELS-1:0] led_r, led_nxt;
  logic [NUM_CHANNELS-1:0] vld_r, vld_nxt;
  logic [NUM_CHANNELS-1:0] done_r, done_nxt;
  logic [CNT_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                    rvld_r, rvld_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Payload registers.
  in_req_t                 req_r, req_nxt;
  logic [IDX_W-1:0]        ridx_r, ridx_nxt;
  out_res_t                out_res_r, out_res_nxt;

  // Channel memory with a registered read port.
  chan_rec_t               chan_mem [NUM_CHANNELS];
  chan_rec_t               mem_rdata_r;
  logic                    mem_rok_r;
  logic                    mem_re, mem_we;
  logic [IDX_W-1:0]        mem_raddr, mem_waddr;
  chan_rec_t               mem_wdata;

  logic [3:0]              n_used;
  logic                    hit;
  logic [IDX_W-1:0]        hit_idx;
  logic                    rd_go;
  logic                    cfg_wr;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  // Channels in use, clamped to the number that exists.
  assign n_used = (cnt_r > 4'(NUM_CHANNELS)) ? 4'(NUM_CHANNELS) : cnt_r;
  assign rd_go  = (rd_idx_r < CNT_W'(n_used));

  // Pin lookup: the lowest channel in use whose table byte equals the pin wins,
  // so the search runs from the top down and lower matches overwrite higher ones.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if ((4'(i) < n_used) && (map_r[PIN_W*i +: PIN_W] == req_r.pin)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_ENABLE: prdata = {63'd0, en_r};
      REG_COUNT:  prdata = {60'd0, cnt_r};
      REG_MAP:    prdata = map_r;
      default:    prdata = 64'd0;
    endcase
  end

  // Sequencer. Commands look the pin up and write, or read, one memory entry. A tick
  // with blinking enabled streams the channels in use through the memory: channel k is
  // read while channel k-1, whose data has just arrived, is updated and written back.
  // The read and write addresses in one cycle therefore always differ.
  always_comb begin
    chan_rec_t   rec;
    logic [31:0] elapsed;
    logic        fin;
    logic        found;
    logic [31:0] left;

    state_nxt     = state_r;
    time_nxt      = time_r;
    active_nxt    = active_r;
    led_nxt       = led_r;
    vld_nxt       = vld_r;
    done_nxt      = done_r;
    rd_idx_nxt    = rd_idx_r;
    rvld_nxt      = 1'b0;
    ridx_nxt      = ridx_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    mem_re        = 1'b0;
    mem_raddr     = rd_idx_r[IDX_W-1:0];
    mem_we        = 1'b0;
    mem_waddr     = ridx_r;
    mem_wdata     = mem_rdata_r;
    rec           = mem_rdata_r;
    elapsed       = 32'd0;
    fin           = 1'b0;
    found         = 1'b0;
    left          = 32'd0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt  = in_req;
          done_nxt = '0;
          if (in_req.action == ACT_TICK) begin
            time_nxt = time_r + 32'd1;
            if (en_r) begin
              state_nxt  = ST_SCAN;
              rd_idx_nxt = '0;
            end else begin
              fin = 1'b1;
            end
          end else begin
            state_nxt = ST_LOOK;
          end
        end
      end

      ST_LOOK: begin
        if (!hit) begin
          fin = 1'b1;
        end else begin
          unique case (req_r.action)
            ACT_START: begin
              mem_we               = 1'b1;
              mem_waddr            = hit_idx;
              mem_wdata.phase      = 1'b1;
              mem_wdata.last_phase = 1'b0;
              mem_wdata.on_ms      = req_r.on_ms;
              mem_wdata.off_ms     = req_r.off_ms;
              mem_wdata.remaining  = req_r.blink_total;
              mem_wdata.stamp      = time_r;
              active_nxt[hit_idx]  = 1'b1;
              vld_nxt[hit_idx]     = 1'b1;
              fin                  = 1'b1;
              found                = 1'b1;
            end
            ACT_STOP: begin
              mem_we              = 1'b1;
              mem_waddr           = hit_idx;
              mem_wdata           = '0;
              active_nxt[hit_idx] = 1'b0;
              led_nxt[hit_idx]    = 1'b0;
              vld_nxt[hit_idx]    = 1'b1;
              fin                 = 1'b1;
              found               = 1'b1;
            end
            ACT_QUERY: begin
              mem_re    = 1'b1;
              mem_raddr = hit_idx;
              ridx_nxt  = hit_idx;
              state_nxt = ST_QRY;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      ST_QRY: begin
        // An entry never written is reported with a count of zero, as its valid flag is clear.
        fin   = 1'b1;
        found = 1'b1;
        left  = mem_rok_r ? mem_rdata_r.remaining : 32'd0;
      end

      ST_SCAN: begin
        if (rd_go) begin
          mem_re     = 1'b1;
          mem_raddr  = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
          rvld_nxt   = 1'b1;
          ridx_nxt   = rd_idx_r[IDX_W-1:0];
        end
        if (rvld_r && active_r[ridx_r]) begin
          if (rec.stamp != 32'd0) begin
            if (rec.phase != rec.last_phase) begin
              rec.last_phase  = rec.phase;
              led_nxt[ridx_r] = rec.phase;
            end
            elapsed = time_r - rec.stamp;
            if (rec.phase) begin
              if (elapsed >= {16'd0, rec.on_ms}) begin
                rec.stamp = time_r;
                rec.phase = 1'b0;
              end
            end else if (elapsed >= {16'd0, rec.off_ms}) begin
              rec.stamp     = time_r;
              rec.phase     = 1'b1;
              rec.remaining = rec.remaining - 32'd1;
            end
          end else begin
            // A zero stamp, from a start taken before the first tick, only takes the current time.
            rec.stamp = time_r;
          end
          if (rec.remaining == 32'd0) begin
            active_nxt[ridx_r] = 1'b0;
            done_nxt[ridx_r]   = 1'b1;
          end
          mem_we    = 1'b1;
          mem_waddr = ridx_r;
          mem_wdata = rec;
        end
        if (!rd_go) begin
          fin = 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt             = ST_IDLE;
      out_valid_nxt         = 1'b1;
      out_res_nxt.led_drive = '0;
      out_res_nxt.done_mask = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        out_res_nxt.led_drive[i] = led_nxt[i];
        out_res_nxt.done_mask[i] = done_nxt[i];
      end
      out_res_nxt.pin_found  = found;
      out_res_nxt.count_left = left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      time_r      <= 32'd0;
      en_r        <= 1'b0;
      cnt_r       <= 4'd0;
      map_r       <= MAP_RESET;
      active_r    <= '0;
      led_r       <= '0;
      vld_r       <= '0;
      done_r      <= '0;
      rd_idx_r    <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      active_r    <= active_nxt;
      led_r       <= led_nxt;
      vld_r       <= vld_nxt;
      done_r      <= done_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        unique case (paddr[4:3])
          REG_ENABLE: en_r  <= pwdata[0];
          REG_COUNT:  cnt_r <= pwdata[3:0];
          REG_MAP:    map_r <= pwdata;
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    ridx_r    <= ridx_nxt;
    out_res_r <= out_res_nxt;
  end

  // Channel memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      chan_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= chan_mem[mem_raddr];
      mem_rok_r   <= vld_r[mem_raddr];
    end
  end

  // A start, stop or query is never answered in the cycle right after it is taken.
  a_cmd_not_immediate: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req.action != ACT_TICK)) |=> !out_valid)
    else $error("command answered without a lookup cycle");

  // Done flags come only from ticks, and a tick never reports a found pin.
  a_found_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.pin_found) |-> (out_res.done_mask == 8'd0))
    else $error("done flags reported with a command result");

  // During a scan the entry being read is never the one being written back.
  a_scan_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_re && mem_we) |-> (mem_raddr != mem_waddr))
    else $error("channel memory read and write hit the same entry");

  // A result strobe follows either a busy period or a request taken while idle.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result strobe without a request");

endmodule
